/* rtl/core/dpc_pkg.sv */
`default_nettype none

package dpc_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_SAT     = 2'd2;

    // Configuration register indexes
    localparam logic CFG_IDX_A = 1'b0;
    localparam logic CFG_IDX_B = 1'b1;

    localparam logic [14:0] MAGNUS_A_RESET = 15'd17620;
    localparam logic [14:0] MAGNUS_B_RESET = 15'd24312;

    // ln(2) in Q30
    localparam logic [30:0] LN2_Q30 = 31'd744261118;

    localparam logic signed [17:0] DEW_MIN = -18'sd20000;
    localparam logic signed [17:0] DEW_MAX = 18'sd13000;

    // Quotient bits of the final divide; larger results saturate
    localparam int DEW_QW = 16;

    // Flags that ride along with the final divide
    typedef struct packed {
        logic inv;
        logic pole;
        logic zero_den;
        logic zero_num;
        logic num_neg;
        logic quo_neg;
        logic ovf;
    } fin_t;

    // Shift-subtract divide, elaboration time only
    function automatic longint unsigned udiv_c(input longint unsigned x,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int k = 63; k >= 0; k--)
        begin
            r = (r << 1) | ((x >> k) & 64'd1);
            if (r >= d)
            begin
                r = r - d;
                q = q | (64'd1 << k);
            end
        end
        return q;
    endfunction

    // log2(1 + i/n) in Q.f by repeated squaring with f+8 bits
    function automatic longint log2_mant_c(input longint i, input longint n, input int f);
        longint unsigned m;
        longint unsigned acc;
        m = (64'd1 << 31) + udiv_c(longint'(i) << 31, longint'(n));
        acc = 0;
        if (m >= (64'd1 << 32))
            return longint'(64'd1 << f);
        for (int k = 0; k < f + 8; k++)
        begin
            m = (m * m) >> 31;
            acc = acc << 1;
            if (m >= (64'd1 << 32))
            begin
                m = m >> 1;
                acc = acc | 64'd1;
            end
        end
        return longint'((acc + 64'd128) >> 8);
    endfunction

    // Interpolated log2(h) in Q.f, same path as the hardware
    function automatic longint log2_interp_c(input longint h, input longint n, input int f);
        int e;
        longint unsigned m;
        longint unsigned prod;
        longint unsigned idx;
        longint unsigned r;
        longint lo;
        longint hi;
        e = 0;
        while (e < 13 && (h >> (e + 1)) != 0)
            e++;
        m = longint'(h) << (31 - e);
        prod = (m - (64'd1 << 31)) * longint'(n);
        idx = prod >> 31;
        r = prod & ((64'd1 << 31) - 1);
        lo = log2_mant_c(longint'(idx), n, f);
        hi = log2_mant_c(longint'(idx) + 1, n, f);
        return (longint'(e) << f) + lo + longint'((longint'(hi - lo) * r + (64'd1 << 30)) >> 31);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/dpc_div.sv */
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Requires num < den << QW; quotient is truncated.
module dpc_div #(
    parameter int DW = 26,
    parameter int QW = 37,
    parameter int SW = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [DW+QW-1:0]     in_num,
    input  wire logic [DW-1:0]        in_den,
    input  wire logic [SW-1:0]        in_side,
    output logic                      out_valid,
    output logic [QW-1:0]             out_quot,
    output logic [SW-1:0]             out_side
);

    localparam int NW = DW + QW;

    logic [NW-1:0] rem_reg  [0:QW-1];
    logic [DW-1:0] den_reg  [0:QW-1];
    logic [QW-1:0] quo_reg  [0:QW];
    logic [SW-1:0] side_reg [0:QW];
    logic          vld_reg  [0:QW];

    // capture stage
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= in_num;
        den_reg[0]  <= in_den;
        quo_reg[0]  <= '0;
        side_reg[0] <= in_side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= in_valid;
    end

    for (genvar g = 0; g < QW; g++)
    begin : g_stage
        localparam int SH = QW - 1 - g;
        logic [NW-1:0] dsh;
        logic          geq;

        assign dsh = NW'(den_reg[g]) << SH;
        assign geq = rem_reg[g] >= dsh;

        always_ff @(posedge clk)
        begin
            quo_reg[g+1]  <= {quo_reg[g][QW-2:0], geq};
            side_reg[g+1] <= side_reg[g];
        end

        if (g < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[g+1] <= geq ? (rem_reg[g] - dsh) : rem_reg[g];
                den_reg[g+1] <= den_reg[g];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g+1] <= 1'b0;
            else
                vld_reg[g+1] <= vld_reg[g];
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_quot  = quo_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

`default_nettype wire

/* rtl/core/dew_point_calculator.sv */
`default_nettype none

// Dew point by the Magnus formula, fully pipelined.
//
// Input: pulse start with a temperature / humidity sample and its two
// present flags; a sample transfers at every edge where start is high and
// busy is low. busy never rises, so a sample may enter every clock.
// Output: done pulses for one cycle with dew_centi and status; the receiver
// cannot hold it off and nothing here waits on it.
// Depth: set by the two bit-per-stage dividers, FRAC_BITS + 21 stages for
// the temperature term and 16 stages for the final quotient, plus the log
// and multiply stages.
// Throughput: one result per cycle, in the order samples were accepted.
// Configuration: cfg_valid/cfg_ready write coefficient a (index 0) or b
// (index 1); cfg_ready is always high. Write only while no sample is in
// flight.
// Reset: drops every in-flight sample and restores a = 17.620, b = 243.12.
module dew_point_calculator #(
    parameter int LOG_TABLE_ENTRIES = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [14:0] temp_centi,
    input  wire logic [13:0]        humidity_centi,
    input  wire logic               temp_present,
    input  wire logic               humidity_present,
    output logic                    done,
    output logic signed [15:0]      dew_centi,
    output logic [1:0]              status,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [14:0]        cfg_data
);

    localparam int F   = FRAC_BITS;
    localparam int N   = LOG_TABLE_ENTRIES;
    localparam int TW  = F + 1;               // table entry
    localparam int IW  = $clog2(N + 1);       // table index
    localparam int PW  = 31 + IW;             // mantissa times N
    localparam int LW  = F + 5;               // signed log2 difference / ln
    localparam int LPW = LW + 31;             // ln product
    localparam int M1W = F + 30;              // |a*T| << F plus rounding
    localparam int D1W = 26;                  // 1000*|b+T|
    localparam int Q1W = F + 21;
    localparam int N1W = D1W + Q1W;
    localparam int GW  = F + 23;              // gamma
    localparam int P2W = GW + 16;             // b*gamma
    localparam int D2W = GW + 1;              // a - gamma
    localparam int M2W = D2W + dpc_pkg::DEW_QW;
    localparam int S1W = 3 + LW;

    // a*2^F/1000 split as a*AQ_K + a*AQ_RM/1000
    localparam int AQ_K  = (1 << F) / 1000;
    localparam int AQ_RM = (1 << F) % 1000;
    // ceil(2^35/1000): exact floor(x/1000) for x below 2^25
    localparam logic [25:0] RECIP_1000 = 26'd34359739;

    localparam longint L10K_VAL = dpc_pkg::log2_interp_c(10000, N, F);
    localparam logic signed [LW-1:0] L10K = LW'(L10K_VAL);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [14:0] a_reg;
    logic [14:0] b_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= dpc_pkg::MAGNUS_A_RESET;
            b_reg <= dpc_pkg::MAGNUS_B_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dpc_pkg::CFG_IDX_A: a_reg <= cfg_data;
                dpc_pkg::CFG_IDX_B: b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Coefficient a in Q.F, rounded: registered from a_reg through ar_reg,
    // aqf_reg and aq_reg, long before a sample reaches the gamma stage
    // ------------------------------------------------------------------
    logic [GW-1:0] ak_reg;
    logic [24:0]   ar_reg;
    logic [GW-1:0] ak2_reg;
    logic [14:0]   aqf_reg;
    logic [GW-1:0] aq_reg;

    always_ff @(posedge clk)
    begin
        ak_reg  <= GW'(a_reg) * GW'(AQ_K);
        // remainder part plus half the divisor for rounding
        ar_reg  <= 25'(a_reg) * 25'(AQ_RM) + 25'd500;
        ak2_reg <= ak_reg;
        aqf_reg <= 15'((51'(ar_reg) * 51'(RECIP_1000)) >> 35);
        aq_reg  <= ak2_reg + GW'(aqf_reg);
    end

    // ------------------------------------------------------------------
    // log2 table, built at elaboration
    // ------------------------------------------------------------------
    logic [TW-1:0] log_tab [0:N];

    for (genvar gi = 0; gi <= N; gi++)
    begin : g_tab
        assign log_tab[gi] = TW'(dpc_pkg::log2_mant_c(gi, N, F));
    end

    // ------------------------------------------------------------------
    // Valid chain through the front stages
    // ------------------------------------------------------------------
    logic v_reg [1:7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 7; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            v_reg[1] <= start && !busy;
            for (int k = 2; k <= 7; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture
    // ------------------------------------------------------------------
    logic signed [14:0] t1_reg;
    logic [13:0]        h1_reg;
    logic               inv1_reg;

    always_ff @(posedge clk)
    begin
        t1_reg   <= temp_centi;
        h1_reg   <= humidity_centi;
        inv1_reg <= !temp_present || !humidity_present || (humidity_centi == 14'd0);
    end

    // ------------------------------------------------------------------
    // Stage 2: a*T, b+T, humidity exponent and table position
    // ------------------------------------------------------------------
    logic [3:0]  e1;
    logic [31:0] m1;
    logic [PW-1:0] pos1;

    always_comb
    begin
        e1 = 4'd0;
        for (int k = 1; k < 14; k++)
        begin
            if (h1_reg[k])
                e1 = 4'(k);
        end
    end

    // drop the leading one, scale the fraction by the entry count
    assign m1   = 32'(h1_reg) << (5'd31 - {1'b0, e1});
    assign pos1 = PW'(m1[30:0]) * PW'(N);

    logic signed [30:0] at2_reg;
    logic signed [16:0] bt2_reg;
    logic               inv2_reg;
    logic [3:0]         e2_reg;
    logic [IW-1:0]      idx2_reg;
    logic [30:0]        r2_reg;

    always_ff @(posedge clk)
    begin
        at2_reg  <= $signed({16'd0, a_reg}) * $signed({{16{t1_reg[14]}}, t1_reg});
        bt2_reg  <= $signed({2'd0, b_reg}) + $signed({{2{t1_reg[14]}}, t1_reg});
        inv2_reg <= inv1_reg;
        e2_reg   <= e1;
        idx2_reg <= pos1[PW-1:31];
        r2_reg   <= pos1[30:0];
    end

    // ------------------------------------------------------------------
    // Stage 3: divider operands for a*T/(b+T), table read
    // ------------------------------------------------------------------
    logic [30:0] at_abs2;
    logic [16:0] bt_abs2;

    assign at_abs2 = at2_reg[30] ? 31'(-at2_reg) : 31'(at2_reg);
    assign bt_abs2 = bt2_reg[16] ? 17'(-bt2_reg) : 17'(bt2_reg);

    typedef struct packed {
        logic           inv;
        logic           pole;
        logic           neg;
        logic [M1W-1:0] mag;
        logic [D1W-1:0] den;
    } prep_t;

    prep_t         prep_reg [3:7];
    logic [3:0]    e3_reg;
    logic [30:0]   r3_reg;
    logic [TW-1:0] lo3_reg;
    logic [TW-1:0] dlt3_reg;

    always_ff @(posedge clk)
    begin
        prep_reg[3].inv  <= inv2_reg;
        prep_reg[3].pole <= (bt2_reg == 17'sd0);
        prep_reg[3].neg  <= at2_reg[30] ^ bt2_reg[16];
        // rounding: add half the divisor before the truncating divide
        prep_reg[3].mag  <= (M1W'(at_abs2[29:0]) << F) + M1W'(26'(bt_abs2) * 26'd500);
        prep_reg[3].den  <= D1W'(bt_abs2) * D1W'(1000);
        e3_reg   <= e2_reg;
        r3_reg   <= r2_reg;
        lo3_reg  <= log_tab[idx2_reg];
        dlt3_reg <= log_tab[IW'(idx2_reg + 1'b1)] - log_tab[idx2_reg];
        for (int k = 4; k <= 7; k++)
            prep_reg[k] <= prep_reg[k-1];
    end

    // ------------------------------------------------------------------
    // Stage 4: interpolation product
    // ------------------------------------------------------------------
    logic [TW+30:0] ip4_reg;
    logic [3:0]     e4_reg;
    logic [TW-1:0]  lo4_reg;

    always_ff @(posedge clk)
    begin
        ip4_reg <= (TW+31)'(dlt3_reg) * (TW+31)'(r3_reg);
        e4_reg  <= e3_reg;
        lo4_reg <= lo3_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: log2(h) - log2(10000)
    // ------------------------------------------------------------------
    logic [TW+31:0] ipr4;
    logic [LW-1:0]  l2h4;

    assign ipr4 = (TW+32)'(ip4_reg) + ((TW+32)'(1) << 30);
    assign l2h4 = (LW'(e4_reg) << F) + LW'(lo4_reg) + LW'(ipr4[TW+31:31]);

    logic signed [LW-1:0] dl5_reg;

    always_ff @(posedge clk)
    begin
        dl5_reg <= $signed(l2h4) - L10K;
    end

    // ------------------------------------------------------------------
    // Stage 6: times ln2
    // ------------------------------------------------------------------
    logic signed [LPW-1:0] lp6_reg;

    always_ff @(posedge clk)
    begin
        lp6_reg <= $signed({{31{dl5_reg[LW-1]}}, dl5_reg}) *
                   $signed(LPW'(dpc_pkg::LN2_Q30));
    end

    // ------------------------------------------------------------------
    // Stage 7: round ln to Q.F
    // ------------------------------------------------------------------
    logic [LPW-1:0] lp_abs6;
    logic [LPW-1:0] lp_rnd6;

    assign lp_abs6 = lp6_reg[LPW-1] ? LPW'(-lp6_reg) : LPW'(lp6_reg);
    assign lp_rnd6 = (lp_abs6 + (LPW'(1) << 29)) >> 30;

    logic signed [LW-1:0] lnv7_reg;

    always_ff @(posedge clk)
    begin
        lnv7_reg <= lp6_reg[LPW-1] ? -$signed(LW'(lp_rnd6)) : $signed(LW'(lp_rnd6));
    end

    // ------------------------------------------------------------------
    // Divider: a*T*2^F/(1000*(b+T)); flags and ln ride alongside
    // ------------------------------------------------------------------
    logic           d1_valid;
    logic [Q1W-1:0] d1_quot;
    logic [S1W-1:0] d1_side;

    dpc_div #(
        .DW (D1W),
        .QW (Q1W),
        .SW (S1W)
    ) u_div_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[7]),
        .in_num    (N1W'(prep_reg[7].mag)),
        .in_den    (prep_reg[7].den),
        .in_side   ({prep_reg[7].inv, prep_reg[7].pole, prep_reg[7].neg, lnv7_reg}),
        .out_valid (d1_valid),
        .out_quot  (d1_quot),
        .out_side  (d1_side)
    );

    // ------------------------------------------------------------------
    // Stage 8: gamma = a*T/(b+T) + ln(RH/100)
    // ------------------------------------------------------------------
    logic signed [GW-1:0] term1_d;
    logic signed [LW-1:0] lnv_d;

    assign term1_d = d1_side[LW] ? -$signed(GW'(d1_quot)) : $signed(GW'(d1_quot));
    assign lnv_d   = $signed(d1_side[LW-1:0]);

    logic                 v8_reg, v9_reg, v10_reg;
    logic signed [GW-1:0] gam8_reg;
    logic signed [GW-1:0] aq8_reg;
    logic                 inv8_reg, pole8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else
        begin
            v8_reg  <= d1_valid;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        gam8_reg  <= term1_d + GW'(lnv_d);
        aq8_reg   <= $signed(aq_reg);
        inv8_reg  <= d1_side[LW+2];
        pole8_reg <= d1_side[LW+1];
    end

    // ------------------------------------------------------------------
    // Stage 9: b*gamma and a - gamma
    // ------------------------------------------------------------------
    logic signed [P2W-1:0] num9_reg;
    logic signed [D2W-1:0] den9_reg;
    logic                  inv9_reg, pole9_reg;

    always_ff @(posedge clk)
    begin
        num9_reg  <= $signed({{(P2W-15){1'b0}}, b_reg}) *
                     $signed({{16{gam8_reg[GW-1]}}, gam8_reg});
        den9_reg  <= $signed({aq8_reg[GW-1], aq8_reg}) - $signed({gam8_reg[GW-1], gam8_reg});
        inv9_reg  <= inv8_reg;
        pole9_reg <= pole8_reg;
    end

    // ------------------------------------------------------------------
    // Stage 10: magnitudes and rounding offset for the final divide
    // ------------------------------------------------------------------
    logic [P2W-1:0] num_abs9;
    logic [D2W-1:0] den_abs9;

    assign num_abs9 = num9_reg[P2W-1] ? P2W'(-num9_reg) : P2W'(num9_reg);
    assign den_abs9 = den9_reg[D2W-1] ? D2W'(-den9_reg) : D2W'(den9_reg);

    logic [M2W-1:0] mag10_reg;
    logic [D2W-1:0] den10_reg;
    dpc_pkg::fin_t  fin10_reg;

    always_ff @(posedge clk)
    begin
        mag10_reg          <= M2W'(num_abs9) + M2W'(den_abs9 >> 1);
        den10_reg          <= den_abs9;
        fin10_reg.inv      <= inv9_reg;
        fin10_reg.pole     <= pole9_reg;
        fin10_reg.zero_den <= (den9_reg == '0);
        fin10_reg.zero_num <= (num9_reg == '0);
        fin10_reg.num_neg  <= num9_reg[P2W-1];
        fin10_reg.quo_neg  <= num9_reg[P2W-1] ^ den9_reg[D2W-1];
        fin10_reg.ovf      <= 1'b0;
    end

    // quotient too large for the divider means certain saturation
    dpc_pkg::fin_t fin10;

    always_comb
    begin
        fin10     = fin10_reg;
        fin10.ovf = mag10_reg >= (M2W'(den10_reg) << dpc_pkg::DEW_QW);
    end

    logic                      d2_valid;
    logic [dpc_pkg::DEW_QW-1:0] d2_quot;
    dpc_pkg::fin_t             d2_side;

    dpc_div #(
        .DW (D2W),
        .QW (dpc_pkg::DEW_QW),
        .SW ($bits(dpc_pkg::fin_t))
    ) u_div_dew (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v10_reg),
        .in_num    (mag10_reg),
        .in_den    (den10_reg),
        .in_side   (fin10),
        .out_valid (d2_valid),
        .out_quot  (d2_quot),
        .out_side  (d2_side)
    );

    // ------------------------------------------------------------------
    // Output stage: sign, clamp, status
    // ------------------------------------------------------------------
    logic signed [17:0] dew_raw;
    logic signed [17:0] dew_next;
    logic [1:0]         status_next;

    assign dew_raw = d2_side.quo_neg ? -$signed(18'(d2_quot)) : $signed(18'(d2_quot));

    always_comb
    begin
        dew_next    = 18'sd0;
        status_next = dpc_pkg::STATUS_OK;
        if (d2_side.inv || d2_side.pole)
        begin
            status_next = dpc_pkg::STATUS_INVALID;
        end
        else if (d2_side.zero_den)
        begin
            if (d2_side.zero_num)
                status_next = dpc_pkg::STATUS_INVALID;
            else
            begin
                status_next = dpc_pkg::STATUS_SAT;
                dew_next    = d2_side.num_neg ? dpc_pkg::DEW_MIN : dpc_pkg::DEW_MAX;
            end
        end
        else if (d2_side.ovf)
        begin
            status_next = dpc_pkg::STATUS_SAT;
            dew_next    = d2_side.quo_neg ? dpc_pkg::DEW_MIN : dpc_pkg::DEW_MAX;
        end
        else if (dew_raw < dpc_pkg::DEW_MIN)
        begin
            status_next = dpc_pkg::STATUS_SAT;
            dew_next    = dpc_pkg::DEW_MIN;
        end
        else if (dew_raw > dpc_pkg::DEW_MAX)
        begin
            status_next = dpc_pkg::STATUS_SAT;
            dew_next    = dpc_pkg::DEW_MAX;
        end
        else
        begin
            dew_next = dew_raw;
        end
    end

    logic               done_reg;
    logic signed [15:0] dew_reg;
    logic [1:0]         status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        dew_reg    <= 16'(dew_next);
        status_reg <= status_next;
    end

    assign done      = done_reg;
    assign dew_centi = dew_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire
